[sv/gcs_pkg.sv]
// Shared types, constants and the sRGB decode table for the gradient color sampler.
package gcs_pkg;

	localparam int MAX_STOPS_DEF = 16;
	localparam int POS_W = 17;
	localparam int COLOR_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GEO_STEPS = 4;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS = 16;
	localparam int ENC_BITS = 8;

	localparam logic [POS_W-1:0] T_ONE = 17'h10000;
	localparam logic [1:0] CH_ALPHA = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd6;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_GEO,
		OP_GEO_DEC,
		OP_SQRT,
		OP_SQRT_END,
		OP_DIV,
		OP_T_SET,
		OP_SAVE,
		OP_PICK,
		OP_BLEND_LOAD,
		OP_F_SET,
		OP_MIX_MUL,
		OP_MIX_ADD,
		OP_ENC,
		OP_ENC_END,
		OP_INS_SHIFT,
		OP_INS_PUT,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] step;
		logic [1:0] ch;
		logic       full;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic gam;
		logic r_direct;
		logic t_le;
		logic t_ge;
	} dp_sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_GEO,
		S_GEO_DEC,
		S_SQRT,
		S_SQRT_END,
		S_DIV_T,
		S_T_SET,
		S_WALK_RD,
		S_WALK_CMP,
		S_LAST_RD,
		S_LAST_CMP,
		S_DIV_F,
		S_F_SET,
		S_MIX_MUL,
		S_MIX_ADD,
		S_ENC,
		S_ENC_END,
		S_FINISH
	} ctrl_state_t;

	typedef logic [POS_W-1:0] lin_tab_t [256];

	function automatic longint unsigned pow5_q30(longint unsigned r);
		longint unsigned p;
		p = r;
		for (int k = 0; k < 4; k++) begin
			p = (p * r) >> 30;
		end
		return p;
	endfunction

	// sRGB decode of c/255 to 16 fraction bits, worked out at elaboration
	function automatic lin_tab_t build_lin();
		lin_tab_t tab;
		longint unsigned u, u2, lo, hi, mid, v;
		for (int c = 0; c < 256; c++) begin
			if (c <= 10) begin
				v = (64'(c) * 64'd6553600 + 64'd164730) / 64'd329460;
			end else begin
				u = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
				u2 = (u * u) >> 30;
				lo = 64'd0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (pow5_q30(mid) <= u2) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
				v = (((u2 * lo) >> 30) + 64'd8192) >> 14;
			end
			tab[c] = v[POS_W-1:0];
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin();

endpackage

[sv/gcs_dp.sv]
// Datapath: config registers, stop table, geometry multiplier, square root, divider, blend.
module gcs_dp import gcs_pkg::*; #(
	parameter int MAX_STOPS = MAX_STOPS_DEF,
	parameter int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic signed [15:0]    pixel_x,
	input  logic signed [15:0]    pixel_y,
	input  logic signed [17:0]    stop_offset,
	input  logic [7:0]            stop_red,
	input  logic [7:0]            stop_green,
	input  logic [7:0]            stop_blue,
	input  logic [7:0]            stop_alpha,
	input  dp_cmd_t               cmd,
	input  logic [IW-1:0]         rd_addr,
	input  logic [IW-1:0]         wr_addr,
	output dp_sts_t               sts,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_alpha,
	output logic                  status
);

	localparam int WORD_W = POS_W + COLOR_W;

	logic                kind_q, gam_q;
	logic signed [23:0]  ox_q, oy_q, ex_q, ey_q, r_q;

	logic signed [15:0]  px_q, py_q;
	logic [COLOR_W-1:0]  new_color_q;
	logic [POS_W-1:0]    t_q, f_q, prev_pos_q;
	logic [COLOR_W-1:0]  prev_color_q, b_color_q, res_color_q;
	logic                res_status_q;

	logic [WORD_W-1:0]   mem [MAX_STOPS];
	logic [WORD_W-1:0]   rd_word_q, wr_word;
	logic                wr_en;
	logic [POS_W-1:0]    rd_pos;
	logic [COLOR_W-1:0]  rd_color;

	logic signed [51:0]  prod_q, acc_a_q, acc_b_q, mul_p;
	logic signed [25:0]  ma, mb;
	logic signed [19:0]  cx, cy;
	logic signed [24:0]  ex, ey, dx, dy;
	logic                r_nonpos, r_direct;

	logic [61:0]         sq_v_q, sq_res_q, sq_bit_q;
	logic [62:0]         sq_sum;
	logic                sq_ge;

	logic signed [52:0]  dl_num, dl_den;
	logic                dl_zero, dl_sat;
	logic [52:0]         rem_q, rem2;
	logic [51:0]         den_q;
	logic [15:0]         q_q;
	logic                sat_q, div_ge;
	logic [POS_W-1:0]    div_res;

	logic                lane;
	logic [7:0]          byte_a, byte_b;
	logic [POS_W-1:0]    mix_a, mix_b, mix_v, mix_v_q;
	logic signed [17:0]  mix_diff;
	logic signed [35:0]  mix_sum;
	logic [7:0]          enc_c_q, probe, enc_next;
	logic [POS_W-1:0]    enc_lo, enc_hi;
	logic                enc_up;
	logic [POS_W-1:0]    offset_clamped;

	logic [7:0]          out_red_q, out_green_q, out_blue_q, out_alpha_q;
	logic                status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
			gam_q  <= 1'b0;
			ox_q   <= '0;
			oy_q   <= '0;
			ex_q   <= '0;
			ey_q   <= '0;
			r_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KIND:   kind_q <= cfg_data[0];
				CFG_GAMMA:  gam_q  <= cfg_data[0];
				CFG_OX:     ox_q   <= cfg_data;
				CFG_OY:     oy_q   <= cfg_data;
				CFG_EX:     ex_q   <= cfg_data;
				CFG_EY:     ey_q   <= cfg_data;
				CFG_RADIUS: r_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stop table: position above color
	assign wr_en = (cmd.op == OP_INS_SHIFT) || (cmd.op == OP_INS_PUT);
	assign wr_word = (cmd.op == OP_INS_SHIFT) ? rd_word_q : {t_q, new_color_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		rd_word_q <= mem[rd_addr];
	end

	assign rd_pos = rd_word_q[WORD_W-1:COLOR_W];
	assign rd_color = rd_word_q[COLOR_W-1:0];

	// geometry
	assign cx = $signed({px_q, 4'b1000});
	assign cy = $signed({py_q, 4'b1000});
	assign ex = 25'(cx) - 25'(ox_q);
	assign ey = 25'(cy) - 25'(oy_q);
	assign dx = 25'(ex_q) - 25'(ox_q);
	assign dy = 25'(ey_q) - 25'(oy_q);
	assign r_nonpos = r_q[23] || (r_q == '0);
	assign r_direct = r_nonpos || (acc_a_q >= acc_b_q);

	// blend operands
	assign lane = gam_q && (cmd.ch != CH_ALPHA);
	assign byte_a = prev_color_q[cmd.ch*8 +: 8];
	assign byte_b = b_color_q[cmd.ch*8 +: 8];
	assign mix_a = lane ? LIN_TAB[byte_a] : {9'b0, byte_a};
	assign mix_b = lane ? LIN_TAB[byte_b] : {9'b0, byte_b};
	assign mix_diff = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});

	always_comb begin
		ma = '0;
		mb = '0;
		if (cmd.op == OP_MIX_MUL) begin
			ma = 26'(mix_diff);
			mb = 26'($signed({1'b0, f_q}));
		end else if (!kind_q) begin
			case (cmd.step[1:0])
				2'd0: begin ma = 26'(ex); mb = 26'(dx); end
				2'd1: begin ma = 26'(ey); mb = 26'(dy); end
				2'd2: begin ma = 26'(dx); mb = 26'(dx); end
				default: begin ma = 26'(dy); mb = 26'(dy); end
			endcase
		end else begin
			case (cmd.step[1:0])
				2'd0: begin ma = 26'(ex); mb = 26'(ex); end
				2'd1: begin ma = 26'(ey); mb = 26'(ey); end
				2'd2: begin ma = 26'(r_q); mb = 26'(r_q); end
				default: begin ma = '0; mb = '0; end
			endcase
		end
	end

	assign mul_p = ma * mb;

	// square root step
	assign sq_sum = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign sq_ge = {1'b0, sq_v_q} >= sq_sum;

	// divider load: q = floor(65536*num/den), saturating at 1.0, zero when either is non-positive
	always_comb begin
		case (cmd.op)
			OP_GEO_DEC: begin
				dl_num = 53'(acc_a_q);
				dl_den = 53'(acc_b_q);
			end
			OP_SQRT_END: begin
				dl_num = $signed({21'b0, sq_res_q[31:0]});
				dl_den = $signed({{21{r_q[23]}}, r_q, 8'b0});
			end
			default: begin
				dl_num = 53'($signed({1'b0, t_q}) - $signed({1'b0, prev_pos_q}));
				dl_den = 53'($signed({1'b0, rd_pos}) - $signed({1'b0, prev_pos_q}));
			end
		endcase
	end

	assign dl_zero = (dl_den <= 53'sd0) || (dl_num <= 53'sd0);
	assign dl_sat = !dl_zero && (dl_num >= dl_den);
	assign rem2 = {rem_q[51:0], 1'b0};
	assign div_ge = rem2 >= {1'b0, den_q};
	assign div_res = sat_q ? T_ONE : {1'b0, q_q};

	assign mix_sum = $signed({3'b0, mix_a, 16'b0}) + 36'(prod_q) + 36'sd32768;
	assign mix_v = mix_sum[35] ? '0 : mix_sum[32:16];

	assign probe = enc_c_q | (8'h1 << cmd.step[2:0]);
	assign enc_next = enc_c_q + 8'd1;
	assign enc_lo = LIN_TAB[enc_c_q];
	assign enc_hi = LIN_TAB[enc_next];
	assign enc_up = (enc_c_q != 8'hFF) && ((mix_v_q - enc_lo) > (enc_hi - mix_v_q));

	assign offset_clamped = stop_offset[17] ? '0 :
		(stop_offset > 18'sd65536) ? T_ONE : stop_offset[POS_W-1:0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				px_q <= pixel_x;
				py_q <= pixel_y;
				new_color_q <= {stop_alpha, stop_blue, stop_green, stop_red};
				t_q <= offset_clamped;
				acc_a_q <= '0;
				acc_b_q <= '0;
				res_color_q <= '0;
				res_status_q <= cmd.full;
			end
			OP_GEO: begin
				if (cmd.step != 5'(GEO_STEPS)) begin
					prod_q <= mul_p;
				end
				if (cmd.step != 5'd0) begin
					if (cmd.step <= 5'd2) begin
						acc_a_q <= acc_a_q + prod_q;
					end else begin
						acc_b_q <= acc_b_q + prod_q;
					end
				end
			end
			OP_GEO_DEC: begin
				if (!kind_q) begin
					rem_q <= (dl_zero || dl_sat) ? '0 : dl_num[52:0];
					den_q <= (dl_zero || dl_sat) ? 52'd1 : dl_den[51:0];
					q_q <= '0;
					sat_q <= dl_sat;
				end else if (r_direct) begin
					t_q <= T_ONE;
				end else begin
					sq_v_q <= {acc_a_q[45:0], 16'b0};
					sq_res_q <= '0;
					sq_bit_q <= 62'h1 << 60;
				end
			end
			OP_SQRT: begin
				if (sq_ge) begin
					sq_v_q <= sq_v_q - sq_sum[61:0];
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_SQRT_END, OP_BLEND_LOAD: begin
				rem_q <= (dl_zero || dl_sat) ? '0 : dl_num[52:0];
				den_q <= (dl_zero || dl_sat) ? 52'd1 : dl_den[51:0];
				q_q <= '0;
				sat_q <= dl_sat;
				if (cmd.op == OP_BLEND_LOAD) begin
					b_color_q <= rd_color;
				end
			end
			OP_DIV: begin
				rem_q <= div_ge ? (rem2 - {1'b0, den_q}) : rem2;
				q_q <= {q_q[14:0], div_ge};
			end
			OP_T_SET: t_q <= div_res;
			OP_F_SET: f_q <= div_res;
			OP_SAVE: begin
				prev_pos_q <= rd_pos;
				prev_color_q <= rd_color;
			end
			OP_PICK: res_color_q <= rd_color;
			OP_MIX_MUL: prod_q <= mul_p;
			OP_MIX_ADD: begin
				mix_v_q <= mix_v;
				enc_c_q <= '0;
				if (!lane) begin
					res_color_q[cmd.ch*8 +: 8] <= (mix_v > 17'd255) ? 8'hFF : mix_v[7:0];
				end
			end
			OP_ENC: begin
				if (LIN_TAB[probe] <= mix_v_q) begin
					enc_c_q <= probe;
				end
			end
			OP_ENC_END: res_color_q[cmd.ch*8 +: 8] <= enc_c_q + {7'b0, enc_up};
			OP_OUT: begin
				out_red_q <= res_color_q[7:0];
				out_green_q <= res_color_q[15:8];
				out_blue_q <= res_color_q[23:16];
				out_alpha_q <= res_color_q[31:24];
				status_q <= res_status_q;
			end
			default: ;
		endcase
	end

	assign sts.kind = kind_q;
	assign sts.gam = gam_q;
	assign sts.r_direct = r_direct;
	assign sts.t_le = t_q <= rd_pos;
	assign sts.t_ge = t_q >= rd_pos;

	assign out_red = out_red_q;
	assign out_green = out_green_q;
	assign out_blue = out_blue_q;
	assign out_alpha = out_alpha_q;
	assign status = status_q;

endmodule

[sv/gcs_ctrl.sv]
// Controller: sequences stop insertion, geometry, root, divisions, stop walk and blend.
module gcs_ctrl import gcs_pkg::*; #(
	parameter int MAX_STOPS = MAX_STOPS_DEF,
	parameter int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          action,
	output logic          out_valid,
	input  logic          out_ready,
	input  dp_sts_t       sts,
	output dp_cmd_t       cmd,
	output logic [IW-1:0] rd_addr,
	output logic [IW-1:0] wr_addr
);

	localparam int CW = $clog2(MAX_STOPS + 1);

	ctrl_state_t   state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [4:0]    cnt_q, cnt_d;
	logic [1:0]    ch_q, ch_d;
	logic [CW-1:0] count_q, count_d;
	logic          out_valid_q, out_load;
	logic          full, last, lane;

	assign full = count_q == CW'(MAX_STOPS);
	assign last = CW'(idx_q) == (count_q - CW'(1));
	assign lane = sts.gam && (ch_q != CH_ALPHA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			ch_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			cnt_q <= cnt_d;
			ch_q <= ch_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cnt_d = cnt_q;
		ch_d = ch_q;
		count_d = count_q;
		cmd = '0;
		cmd.op = OP_NOP;
		cmd.step = cnt_q;
		cmd.ch = ch_q;
		rd_addr = idx_q;
		wr_addr = idx_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					cnt_d = '0;
					if (!action) begin
						cmd.full = full;
						idx_d = IW'(count_q);
						state_d = full ? S_FINISH : S_INS_RD;
					end else begin
						state_d = (count_q == '0) ? S_FINISH : S_GEO;
					end
				end
			end
			S_INS_RD: begin
				rd_addr = idx_q - IW'(1);
				state_d = (idx_q == '0) ? S_INS_PUT : S_INS_CMP;
			end
			S_INS_CMP: begin
				// later stops with a larger position move up one slot
				if (!sts.t_ge) begin
					cmd.op = OP_INS_SHIFT;
					idx_d = idx_q - IW'(1);
					state_d = S_INS_RD;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				cmd.op = OP_INS_PUT;
				count_d = count_q + CW'(1);
				state_d = S_FINISH;
			end
			S_GEO: begin
				cmd.op = OP_GEO;
				if (cnt_q == 5'(GEO_STEPS)) begin
					cnt_d = '0;
					state_d = S_GEO_DEC;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_GEO_DEC: begin
				cmd.op = OP_GEO_DEC;
				idx_d = '0;
				if (!sts.kind) begin
					state_d = S_DIV_T;
				end else if (sts.r_direct) begin
					state_d = S_WALK_RD;
				end else begin
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					cnt_d = '0;
					state_d = S_SQRT_END;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_SQRT_END: begin
				cmd.op = OP_SQRT_END;
				state_d = S_DIV_T;
			end
			S_DIV_T: begin
				cmd.op = OP_DIV;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cnt_d = '0;
					state_d = S_T_SET;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_T_SET: begin
				cmd.op = OP_T_SET;
				idx_d = '0;
				state_d = S_WALK_RD;
			end
			S_WALK_RD: begin
				state_d = S_WALK_CMP;
			end
			S_WALK_CMP: begin
				if (idx_q == '0) begin
					if (sts.t_le || last) begin
						cmd.op = OP_PICK;
						state_d = S_FINISH;
					end else begin
						cmd.op = OP_SAVE;
						idx_d = idx_q + IW'(1);
						state_d = S_LAST_RD;
					end
				end else if (last && sts.t_ge) begin
					cmd.op = OP_PICK;
					state_d = S_FINISH;
				end else if (sts.t_le) begin
					cmd.op = OP_BLEND_LOAD;
					cnt_d = '0;
					state_d = S_DIV_F;
				end else begin
					cmd.op = OP_SAVE;
					idx_d = idx_q + IW'(1);
					state_d = S_WALK_RD;
				end
			end
			S_LAST_RD: begin
				rd_addr = IW'(count_q - CW'(1));
				state_d = S_LAST_CMP;
			end
			S_LAST_CMP: begin
				// at or past the last stop takes its color outright
				if (sts.t_ge) begin
					cmd.op = OP_PICK;
					state_d = S_FINISH;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_DIV_F: begin
				cmd.op = OP_DIV;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cnt_d = '0;
					state_d = S_F_SET;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_F_SET: begin
				cmd.op = OP_F_SET;
				ch_d = '0;
				state_d = S_MIX_MUL;
			end
			S_MIX_MUL: begin
				cmd.op = OP_MIX_MUL;
				state_d = S_MIX_ADD;
			end
			S_MIX_ADD: begin
				cmd.op = OP_MIX_ADD;
				if (lane) begin
					cnt_d = 5'(ENC_BITS - 1);
					state_d = S_ENC;
				end else if (ch_q == CH_ALPHA) begin
					state_d = S_FINISH;
				end else begin
					ch_d = ch_q + 2'd1;
					state_d = S_MIX_MUL;
				end
			end
			S_ENC: begin
				// one bit of the nearest-code search per cycle, msb first
				cmd.op = OP_ENC;
				if (cnt_q == '0) begin
					state_d = S_ENC_END;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			S_ENC_END: begin
				cmd.op = OP_ENC_END;
				ch_d = ch_q + 2'd1;
				state_d = S_MIX_MUL;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_OUT;
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_STOPS))
		else $error("stop count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + CW'(1))
		else $error("stop count moved by more than one");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted word not processed");

	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && (!out_valid_q || out_ready) |=> out_valid_q && state_q == S_IDLE)
		else $error("result word not presented");

endmodule

[sv/gradient_color_sampler_core.sv]
// Top level of the gradient color sampler: controller plus datapath.
//
//  channel | signals                                         | flow
//  cfg     | cfg_we, cfg_index, cfg_data                     | write only, no stall
//  in      | in_valid/in_ready, action, pixel_*, stop_*      | valid/ready
//  out     | out_valid/out_ready, out_*, status              | valid/ready
//
// One word at a time. Add: stops with a larger position move up one slot, then the new stop
// is written; a full table stores nothing and sets status. Sample: an empty table gives a
// zero color. Otherwise geometry multiplies, a 16-step divide (radial adds a 31-step root;
// outside the radius both are skipped), the stop walk with a last-stop check, a second
// 16-step divide for the blend, then a per-channel blend and gamma-mode nearest-code encode.
// Reset clears the config registers and the stop count; the table itself is not cleared.
// A finished result waits in the output register while the next word is accepted; the word
// after it holds in its last cycle until that register is read.
module gradient_color_sampler_core import gcs_pkg::*; #(
	parameter int MAX_STOPS = MAX_STOPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic signed [15:0]    pixel_x,
	input  logic signed [15:0]    pixel_y,
	input  logic signed [17:0]    stop_offset,
	input  logic [7:0]            stop_red,
	input  logic [7:0]            stop_green,
	input  logic [7:0]            stop_blue,
	input  logic [7:0]            stop_alpha,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_alpha,
	output logic                  status
);

	localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [IW-1:0] rd_addr, wr_addr;

	gcs_ctrl #(
		.MAX_STOPS(MAX_STOPS),
		.IW(IW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr)
	);

	gcs_dp #(
		.MAX_STOPS(MAX_STOPS),
		.IW(IW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.stop_offset(stop_offset),
		.stop_red(stop_red),
		.stop_green(stop_green),
		.stop_blue(stop_blue),
		.stop_alpha(stop_alpha),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.sts(sts),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha),
		.status(status)
	);

endmodule
